@@ rtl/core/sso_pkg.sv @@
// ----------------------------------------------------------------------------
// Sweep operator package
// Shared constants and Q32.32 helper functions for the sweep engine.
// ----------------------------------------------------------------------------
package sso_pkg;

  localparam int unsigned MaxVarsDefault = 16;
  localparam int unsigned DataW = 64;
  localparam int unsigned IdxW = 5;

  localparam logic [1:0] CmdWrite = 2'd0;
  localparam logic [1:0] CmdSweep = 2'd1;
  localparam logic [1:0] CmdMask  = 2'd2;
  localparam logic [1:0] CmdRead  = 2'd3;

  localparam logic signed [63:0] QMax = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] QMin = -64'sh7FFF_FFFF_FFFF_FFFF - 64'sd1;
  localparam logic signed [63:0] QMinusOne = -64'sh0000_0001_0000_0000;

  function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic [63:0] r;
    begin
      r = a - b;
      if (a[63] != b[63] && r[63] != a[63]) begin
        sat_sub = a[63] ? QMin : QMax;
      end else begin
        sat_sub = r;
      end
    end
  endfunction

  function automatic logic signed [63:0] sat_neg(input logic signed [63:0] x);
    begin
      sat_neg = (x == QMin) ? QMax : -x;
    end
  endfunction

  function automatic logic signed [63:0] signed_sat(input logic [63:0] mag,
                                                    input logic neg,
                                                    input logic ovf);
    begin
      if (!neg) begin
        signed_sat = (ovf || mag[63]) ? QMax : mag;
      end else if (ovf || mag[63]) begin
        signed_sat = QMin;
      end else begin
        signed_sat = -mag;
      end
    end
  endfunction

  function automatic logic [63:0] mag_of(input logic signed [63:0] x);
    begin
      mag_of = x[63] ? (64'd0 - x) : x;
    end
  endfunction

endpackage

@@ rtl/core/sso_mul.sv @@
// ----------------------------------------------------------------------------
// Sweep operator multiplier
// Q32.32 saturating multiply from four 32x32 partial products on one multiplier.
// ----------------------------------------------------------------------------
module sso_mul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] a_i,
  input  logic signed [63:0] b_i,
  output logic               done_o,
  output logic signed [63:0] p_o
);

  logic [63:0]  ma_q, mb_q;
  logic         neg_q;
  logic [2:0]   step_q;
  logic         run_q;
  logic [127:0] acc_q;
  logic [31:0]  opa, opb;
  logic [63:0]  prod_q;
  logic [127:0] sh;

  always_comb begin
    unique case (step_q[1:0])
      2'd0: begin opa = ma_q[31:0];  opb = mb_q[31:0];  end
      2'd1: begin opa = ma_q[31:0];  opb = mb_q[63:32]; end
      2'd2: begin opa = ma_q[63:32]; opb = mb_q[31:0];  end
      default: begin opa = ma_q[63:32]; opb = mb_q[63:32]; end
    endcase
  end

  always_comb begin
    unique case (step_q[1:0])
      2'd1: sh = {64'd0, prod_q};
      2'd2: sh = {32'd0, prod_q, 32'd0};
      2'd3: sh = {32'd0, prod_q, 32'd0};
      default: sh = {prod_q, 64'd0};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      step_q <= 3'd0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        run_q  <= 1'b1;
        step_q <= 3'd0;
        ma_q   <= sso_pkg::mag_of(a_i);
        mb_q   <= sso_pkg::mag_of(b_i);
        neg_q  <= a_i[63] ^ b_i[63];
        acc_q  <= 128'd0;
      end else if (run_q) begin
        prod_q <= opa * opb;
        step_q <= step_q + 3'd1;
        if (step_q != 3'd0) begin
          acc_q <= acc_q + sh;
        end
        if (step_q == 3'd4) begin
          run_q  <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  // Product of step k lands in prod_q in the next cycle; shift matches step k-1.
  assign p_o = sso_pkg::signed_sat(acc_q[95:32], neg_q, acc_q[127:96] != 32'd0);

endmodule

@@ rtl/core/sso_div.sv @@
// ----------------------------------------------------------------------------
// Sweep operator divider
// Q32.32 saturating restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sso_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] x_i,
  input  logic signed [63:0] y_i,
  output logic               done_o,
  output logic signed [63:0] q_o
);

  logic [95:0] num_q;
  logic [63:0] d_q;
  logic [64:0] r_q;
  logic [95:0] quo_q;
  logic [6:0]  cnt_q;
  logic        run_q, neg_q;
  logic [64:0] rs;

  assign rs = {r_q[63:0], num_q[95]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= 7'd0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= 7'd0;
        num_q <= {sso_pkg::mag_of(x_i), 32'd0};
        d_q   <= sso_pkg::mag_of(y_i);
        r_q   <= 65'd0;
        quo_q <= 96'd0;
        neg_q <= x_i[63] ^ y_i[63];
      end else if (run_q) begin
        num_q <= {num_q[94:0], 1'b0};
        if (rs >= {1'b0, d_q}) begin
          r_q   <= rs - {1'b0, d_q};
          quo_q <= {quo_q[94:0], 1'b1};
        end else begin
          r_q   <= rs;
          quo_q <= {quo_q[94:0], 1'b0};
        end
        cnt_q <= cnt_q + 7'd1;
        if (cnt_q == 7'd95) begin
          run_q  <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  assign q_o = sso_pkg::signed_sat(quo_q[63:0], neg_q, quo_q[95:64] != 32'd0);

endmodule

@@ rtl/core/symmetric_sweep_operator_engine_core.sv @@
// ----------------------------------------------------------------------------
// Symmetric sweep operator engine
// Packed symmetric matrix store with write, read, single and mask sweeps.
// ----------------------------------------------------------------------------
// A write goes through StFinish to its result strobe, a read through StRdWait,
// StRdOut and StFinish. A single sweep divides the pivot and each column entry
// serially, then updates the rest of the packed triangle; a mask sweep repeats
// that per swept column. A zero or out-of-range pivot ends a single sweep early.
// Throughput: one request at a time; busy is high until the result strobe,
// and the receiver cannot stall. Reset clears control state only.
module symmetric_sweep_operator_engine_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         cmd_i,
  input  logic [4:0]         row_i,
  input  logic [4:0]         col_i,
  input  logic signed [63:0] value_i,
  input  logic [4:0]         sweep_column_i,
  input  logic               reverse_i,
  input  logic [15:0]        observed_mask_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [4:0]         cfg_data_i,
  output logic               done_o,
  output logic signed [63:0] read_value_o,
  output logic               status_o
);

  localparam int unsigned MaxVars = sso_pkg::MaxVarsDefault;
  localparam int unsigned Depth = (MaxVars + 1) * (MaxVars + 2) / 2;
  localparam int unsigned AW = $clog2(Depth);
  localparam int unsigned SW = $clog2(MaxVars + 2);

  typedef enum logic [4:0] {
    StIdle, StRdWait, StRdOut, StMaskNext, StMaskDiag, StMaskChk,
    StPivRd, StPivWait, StPivChk, StDivStart, StDivWait,
    StColRd, StColWait, StColDiv, StColDivWait,
    StUpdJ, StUpdL, StUpdRd1, StUpdRd2, StUpdMul1, StUpdMul1W,
    StUpdMul2W, StUpdWr, StFinish
  } state_e;

  logic signed [63:0] mem [Depth];
  logic signed [63:0] rdata_q;
  logic [AW-1:0]      raddr, waddr;
  logic               we;
  logic signed [63:0] wdata;

  state_e             state_q;
  logic [SW-1:0]      side_q, k_q, j_q, l_q, i_q;
  logic               rev_q, mask_q, stat_q;
  logic [15:0]        obs_q;
  logic signed [63:0] a_q, tjk_q, t_q;
  logic [4:0]         row_q, col_q;
  logic               done_q;
  logic signed [63:0] rv_q;

  logic               div_go, mul_go, div_done, mul_done;
  logic signed [63:0] div_x, mul_a, mul_b, div_q, mul_p;

  function automatic logic [AW-1:0] pos(input logic [SW-1:0] i, input logic [SW-1:0] j);
    logic [SW-1:0] lo, hi;
    logic [2*SW:0] p;
    begin
      lo = (i < j) ? i : j;
      hi = (i < j) ? j : i;
      p = (({{(SW+1){1'b0}}, hi} * {{(SW+1){1'b0}}, hi + {{(SW-1){1'b0}}, 1'b1}}) >> 1)
          + {{(SW+1){1'b0}}, lo};
      pos = p[AW-1:0];
    end
  endfunction

  sso_div u_div (.clk_i, .rst_ni, .start_i(div_go), .x_i(div_x), .y_i(a_q),
                 .done_o(div_done), .q_o(div_q));
  sso_mul u_mul (.clk_i, .rst_ni, .start_i(mul_go), .a_i(mul_a), .b_i(mul_b),
                 .done_o(mul_done), .p_o(mul_p));

  assign busy = (state_q != StIdle);
  assign cfg_ready_o = (state_q == StIdle);
  assign done_o = done_q;
  assign read_value_o = rv_q;
  assign status_o = stat_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  always_comb begin
    raddr  = pos(j_q, l_q);
    we     = 1'b0;
    waddr  = pos(j_q, l_q);
    wdata  = t_q;
    div_go = 1'b0;
    div_x  = sso_pkg::QMinusOne;
    mul_go = 1'b0;
    mul_a  = a_q;
    mul_b  = tjk_q;
    unique case (state_q)
      StIdle: raddr = pos(row_i[SW-1:0], col_i[SW-1:0]);
      StRdWait: raddr = pos(row_q[SW-1:0], col_q[SW-1:0]);
      StDivStart: div_go = 1'b1;
      StDivWait: begin
        we = div_done;
        waddr = pos(k_q, k_q);
        wdata = div_q;
      end
      StColDiv: begin
        div_go = 1'b1;
        div_x = rdata_q;
      end
      StColDivWait: begin
        we = div_done;
        waddr = pos(j_q, k_q);
        wdata = rev_q ? sso_pkg::sat_neg(div_q) : div_q;
      end
      StUpdRd1: raddr = pos(j_q, k_q);
      StUpdRd2: raddr = pos(l_q, k_q);
      StUpdMul1: begin
        mul_go = 1'b1;
        raddr = pos(l_q, k_q);
      end
      StUpdMul1W: begin
        raddr = pos(l_q, k_q);
        mul_go = mul_done;
        mul_a = mul_p;
        mul_b = rdata_q;
      end
      StUpdMul2W: raddr = pos(j_q, l_q);
      StUpdWr: begin
        we = 1'b1;
        wdata = sso_pkg::sat_sub(rdata_q, t_q);
      end
      StMaskDiag, StPivRd, StPivWait: raddr = pos(k_q, k_q);
      StColRd, StColWait: raddr = pos(j_q, k_q);
      default: ;
    endcase
    if (state_q == StIdle && start && cmd_i == sso_pkg::CmdWrite
        && {1'b0, row_i} < {1'b0, side_q} && {1'b0, col_i} < {1'b0, side_q}) begin
      we = 1'b1;
      waddr = pos(row_i[SW-1:0], col_i[SW-1:0]);
      wdata = value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      done_q  <= 1'b0;
      stat_q  <= 1'b0;
      rv_q    <= 64'sd0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (start) begin
            row_q <= row_i;
            col_q <= col_i;
            rev_q <= reverse_i;
            obs_q <= observed_mask_i;
            mask_q <= (cmd_i == sso_pkg::CmdMask);
            rv_q <= 64'sd0;
            stat_q <= 1'b0;
            unique case (cmd_i)
              sso_pkg::CmdWrite: state_q <= StFinish;
              sso_pkg::CmdRead: state_q <= StRdWait;
              sso_pkg::CmdSweep: begin
                if ({1'b0, sweep_column_i} < {1'b0, side_q}) begin
                  k_q <= sweep_column_i[SW-1:0];
                  state_q <= StPivRd;
                end else begin
                  state_q <= StFinish;
                end
              end
              default: begin
                i_q <= '0;
                state_q <= StMaskNext;
              end
            endcase
          end
        end
        StRdWait: state_q <= StRdOut;
        StRdOut: begin
          if ({1'b0, row_q} < {1'b0, side_q} && {1'b0, col_q} < {1'b0, side_q}) begin
            rv_q <= rdata_q;
          end
          state_q <= StFinish;
        end
        StMaskNext: begin
          if (i_q + 1'b1 < side_q) begin
            k_q <= i_q + 1'b1;
            state_q <= StMaskDiag;
          end else begin
            state_q <= StFinish;
          end
        end
        StMaskDiag: state_q <= StMaskChk;
        StMaskChk: begin
          i_q <= i_q + 1'b1;
          a_q <= rdata_q;
          if ({{(8-SW){1'b0}}, i_q} < 8'd16 && obs_q[i_q[3:0]]) begin
            rev_q <= 1'b0;
            state_q <= (rdata_q > 0) ? StDivStart : StMaskNext;
          end else begin
            rev_q <= 1'b1;
            state_q <= (rdata_q < 0) ? StDivStart : StMaskNext;
          end
        end
        StPivRd: state_q <= StPivWait;
        StPivWait: state_q <= StPivChk;
        StPivChk: begin
          a_q <= rdata_q;
          if (rdata_q == 64'sd0) begin
            stat_q <= 1'b1;
            state_q <= StFinish;
          end else begin
            state_q <= StDivStart;
          end
        end
        StDivStart: state_q <= StDivWait;
        StDivWait: begin
          if (div_done) begin
            j_q <= '0;
            state_q <= StColRd;
          end
        end
        StColRd: begin
          if (j_q == side_q) begin
            j_q <= '0;
            state_q <= StUpdJ;
          end else if (j_q == k_q) begin
            j_q <= j_q + 1'b1;
          end else begin
            state_q <= StColWait;
          end
        end
        StColWait: state_q <= StColDiv;
        StColDiv: state_q <= StColDivWait;
        StColDivWait: begin
          if (div_done) begin
            j_q <= j_q + 1'b1;
            state_q <= StColRd;
          end
        end
        StUpdJ: begin
          if (j_q == side_q) begin
            state_q <= mask_q ? StMaskNext : StFinish;
          end else if (j_q == k_q) begin
            j_q <= j_q + 1'b1;
          end else begin
            l_q <= j_q;
            state_q <= StUpdL;
          end
        end
        StUpdL: begin
          if (l_q == side_q) begin
            j_q <= j_q + 1'b1;
            state_q <= StUpdJ;
          end else if (l_q == k_q) begin
            l_q <= l_q + 1'b1;
          end else begin
            state_q <= StUpdRd1;
          end
        end
        StUpdRd1: state_q <= StUpdRd2;
        StUpdRd2: begin
          tjk_q <= rdata_q;
          state_q <= StUpdMul1;
        end
        StUpdMul1: state_q <= StUpdMul1W;
        StUpdMul1W: begin
          if (mul_done) begin
            state_q <= StUpdMul2W;
          end
        end
        StUpdMul2W: begin
          if (mul_done) begin
            t_q <= mul_p;
            state_q <= StUpdWr;
          end
        end
        StUpdWr: begin
          l_q <= l_q + 1'b1;
          state_q <= StUpdL;
        end
        StFinish: begin
          done_q <= 1'b1;
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // Effective side length: the variable count clamped to [1, MaxVars], plus one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= SW'(MaxVars + 1);
    end else if (state_q == StIdle && cfg_valid_i) begin
      if (cfg_data_i == 5'd0) begin
        side_q <= SW'(2);
      end else if ({27'd0, cfg_data_i} > MaxVars) begin
        side_q <= SW'(MaxVars + 1);
      end else begin
        side_q <= SW'({27'd0, cfg_data_i} + 32'd1);
      end
    end
  end

endmodule

@@ sim/symmetric_sweep_operator_engine_core_tb.sv @@
// ----------------------------------------------------------------------------
// Sweep engine testbench
// Drives write, read, single sweep and mask sweep requests through several
// matrix sizes, predicts every result in Q32.32 and checks it on the strobe.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module symmetric_sweep_operator_engine_core_tb;

  localparam int unsigned StoreDepth = 153;
  localparam int unsigned IdleLimit = 200000;
  localparam logic signed [63:0] QOne = 64'sh0000_0001_0000_0000;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [4:0]         row;
    logic [4:0]         col;
    logic signed [63:0] value;
    logic [4:0]         pivot;
    logic               rev;
    logic [15:0]        mask;
  } sweep_req_t;

  typedef struct packed {
    logic signed [63:0] rd;
    logic               status;
  } sweep_rsp_t;

  class sweep_scoreboard;
    logic signed [63:0] mat[StoreDepth];
    logic [4:0] vars_reg;
    sweep_rsp_t expected_q[$];
    int errors;

    function new();
      vars_reg = 5'd16;
      errors = 0;
      foreach (mat[i]) mat[i] = '0;
    endfunction

    function int unsigned side();
      int unsigned v;
      v = vars_reg;
      if (v < 1) v = 1;
      if (v > 16) v = 16;
      return v + 1;
    endfunction

    function int unsigned slot(int unsigned i, int unsigned j);
      int unsigned lo, hi;
      lo = (i < j) ? i : j;
      hi = (i < j) ? j : i;
      return hi * (hi + 1) / 2 + lo;
    endfunction

    function logic signed [63:0] clamp_mag(logic [63:0] mag, logic neg, logic ovf);
      if (!neg) return (ovf || mag[63]) ? sso_pkg::QMax : mag;
      if (ovf || mag[63]) return sso_pkg::QMin;
      return -mag;
    endfunction

    function logic [63:0] abs_of(logic signed [63:0] x);
      return x[63] ? 64'd0 - x : x;
    endfunction

    function logic signed [63:0] q_product(logic signed [63:0] a, logic signed [63:0] b);
      logic [127:0] p;
      p = {64'd0, abs_of(a)} * {64'd0, abs_of(b)};
      return clamp_mag(p[95:32], a[63] ^ b[63], |p[127:96]);
    endfunction

    function logic signed [63:0] q_quotient(logic signed [63:0] a, logic signed [63:0] b);
      logic [95:0] n, q;
      n = {abs_of(a), 32'd0};
      q = n / {32'd0, abs_of(b)};
      return clamp_mag(q[63:0], a[63] ^ b[63], |q[95:64]);
    endfunction

    function logic signed [63:0] clamp_sub(logic signed [63:0] a, logic signed [63:0] b);
      logic [63:0] r;
      r = a - b;
      if (a[63] != b[63] && r[63] != a[63]) return a[63] ? sso_pkg::QMin : sso_pkg::QMax;
      return r;
    endfunction

    function logic signed [63:0] clamp_neg(logic signed [63:0] x);
      return (x == sso_pkg::QMin) ? sso_pkg::QMax : -x;
    endfunction

    function logic pivot_sweep(int unsigned s, int unsigned k, logic rev);
      logic signed [63:0] a, q, t;
      a = mat[slot(k, k)];
      if (a == 0) return 1'b1;
      mat[slot(k, k)] = q_quotient(sso_pkg::QMinusOne, a);
      for (int unsigned j = 0; j < s; j++) begin
        if (j != k) begin
          q = q_quotient(mat[slot(j, k)], a);
          mat[slot(j, k)] = rev ? clamp_neg(q) : q;
        end
      end
      for (int unsigned j = 0; j < s; j++) begin
        if (j == k) continue;
        for (int unsigned l = j; l < s; l++) begin
          if (l != k) begin
            t = q_product(q_product(a, mat[slot(j, k)]), mat[slot(l, k)]);
            mat[slot(j, l)] = clamp_sub(mat[slot(j, l)], t);
          end
        end
      end
      return 1'b0;
    endfunction

    function void note(sweep_req_t r);
      sweep_rsp_t e;
      int unsigned s;
      logic signed [63:0] dg;
      s = side();
      e = '0;
      case (r.cmd)
        sso_pkg::CmdWrite: begin
          if (r.row < s && r.col < s) mat[slot(r.row, r.col)] = r.value;
        end
        sso_pkg::CmdSweep: begin
          if (r.pivot < s) e.status = pivot_sweep(s, r.pivot, r.rev);
        end
        sso_pkg::CmdMask: begin
          for (int unsigned i = 0; i + 1 < s; i++) begin
            dg = mat[slot(i + 1, i + 1)];
            if (r.mask[i] && dg > 0) void'(pivot_sweep(s, i + 1, 1'b0));
            else if (!r.mask[i] && dg < 0) void'(pivot_sweep(s, i + 1, 1'b1));
          end
        end
        default: begin
          if (r.row < s && r.col < s) e.rd = mat[slot(r.row, r.col)];
        end
      endcase
      expected_q.push_back(e);
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check(logic signed [63:0] rd, logic status);
      sweep_rsp_t e;
      if (expected_q.size() == 0) begin
        report("result with no request pending");
        return;
      end
      e = expected_q.pop_front();
      if (rd !== e.rd) report($sformatf("read_value %h, expected %h", rd, e.rd));
      if (status !== e.status) report($sformatf("status %b, expected %b", status, e.status));
    endtask
  endclass

  logic clk_i, rst_ni;
  logic start, busy, done_o;
  logic [1:0] cmd_i;
  logic [4:0] row_i, col_i, sweep_column_i;
  logic signed [63:0] value_i;
  logic reverse_i;
  logic [15:0] observed_mask_i;
  logic cfg_valid_i, cfg_ready_o;
  logic [4:0] cfg_data_i;
  logic signed [63:0] read_value_o;
  logic status_o;

  sweep_scoreboard sb;
  int unsigned idle_cycles;

  symmetric_sweep_operator_engine_core dut (
    .clk_i, .rst_ni, .start, .busy, .cmd_i, .row_i, .col_i, .value_i,
    .sweep_column_i, .reverse_i, .observed_mask_i, .cfg_valid_i, .cfg_ready_o,
    .cfg_data_i, .done_o, .read_value_o, .status_o
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check(read_value_o, status_o);
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || !rst_ni) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("FAIL symmetric_sweep_operator_engine_core");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic signed [63:0] pick_value();
    logic signed [63:0] v;
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = sso_pkg::QMax;
      2: v = sso_pkg::QMin;
      3: v = {$urandom(), $urandom()};
      default: begin
        v = {32'd0, $urandom()};
        v = v + (64'($urandom_range(0, 8)) << 32) - (64'sd4 <<< 32);
      end
    endcase
    return v;
  endfunction

  function automatic sweep_req_t noise_req();
    logic [127:0] bits;
    bits = {$urandom(), $urandom(), $urandom(), $urandom()};
    return bits[$bits(sweep_req_t)-1:0];
  endfunction

  task automatic send_req(sweep_req_t r);
    start <= 1'b1;
    cmd_i <= r.cmd;
    row_i <= r.row;
    col_i <= r.col;
    value_i <= r.value;
    sweep_column_i <= r.pivot;
    reverse_i <= r.rev;
    observed_mask_i <= r.mask;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note(r);
  endtask

  task automatic send_op(logic [1:0] cmd, int unsigned row, int unsigned col,
                         logic signed [63:0] value, int unsigned pivot, logic rev,
                         logic [15:0] mask);
    sweep_req_t r;
    r = noise_req();
    r.cmd = cmd;
    r.row = 5'(row);
    r.col = 5'(col);
    r.value = value;
    r.pivot = 5'(pivot);
    r.rev = rev;
    r.mask = mask;
    send_req(r);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_vars(logic [4:0] v);
    drain();
    repeat (10) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    sb.vars_reg = v;
  endtask

  task automatic fill_matrix();
    int unsigned s;
    s = sb.side();
    for (int unsigned j = 0; j < s; j++) begin
      for (int unsigned i = 0; i <= j; i++) begin
        send_op(sso_pkg::CmdWrite, i, j, pick_value(), 0, 1'b0, 16'h0);
      end
    end
  endtask

  task automatic random_phase(logic [4:0] vars, int unsigned count);
    sweep_req_t r;
    int unsigned s, burst, gap, sel;
    set_vars(vars);
    fill_matrix();
    s = sb.side();
    burst = $urandom_range(1, 20);
    for (int unsigned n = 0; n < count; n++) begin
      r = noise_req();
      sel = $urandom_range(0, 99);
      if ($urandom_range(0, 9) != 0) begin
        r.row = 5'($urandom_range(0, s - 1));
        r.col = 5'($urandom_range(0, s - 1));
        r.pivot = 5'($urandom_range(0, s - 1));
      end
      if (sel < 35) begin
        r.cmd = sso_pkg::CmdWrite;
        r.value = pick_value();
      end else if (sel < 65) begin
        r.cmd = sso_pkg::CmdRead;
      end else if (sel < 90) begin
        r.cmd = sso_pkg::CmdSweep;
      end else begin
        r.cmd = sso_pkg::CmdMask;
      end
      send_req(r);
      if (n == count / 2) begin
        drain();
      end else if (--burst == 0) begin
        burst = $urandom_range(1, 20);
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        if (gap != 0) begin
          start <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end
  endtask

  initial begin
    sb = new();
    idle_cycles = 0;
    rst_ni <= 1'b0;
    start <= 1'b0;
    cmd_i <= sso_pkg::CmdWrite;
    row_i <= '0;
    col_i <= '0;
    value_i <= '0;
    sweep_column_i <= '0;
    reverse_i <= 1'b0;
    observed_mask_i <= '0;
    cfg_valid_i <= 1'b0;
    cfg_data_i <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_vars(5'd2);
    fill_matrix();
    send_op(sso_pkg::CmdWrite, 2, 1, sso_pkg::QMax, 0, 1'b0, 16'h0);
    send_op(sso_pkg::CmdRead, 1, 2, '0, 0, 1'b0, 16'h0);
    send_op(sso_pkg::CmdRead, 31, 0, '0, 0, 1'b0, 16'h0);
    send_op(sso_pkg::CmdWrite, 3, 0, sso_pkg::QMin, 0, 1'b0, 16'h0);
    send_op(sso_pkg::CmdWrite, 0, 31, sso_pkg::QMin, 0, 1'b0, 16'h0);
    send_op(sso_pkg::CmdRead, 0, 0, '0, 0, 1'b0, 16'h0);
    send_op(sso_pkg::CmdWrite, 1, 1, '0, 0, 1'b0, 16'h0);
    send_op(sso_pkg::CmdSweep, 0, 0, '0, 1, 1'b0, 16'h0);
    send_op(sso_pkg::CmdWrite, 1, 1, QOne <<< 1, 0, 1'b0, 16'h0);
    send_op(sso_pkg::CmdSweep, 0, 0, '0, 1, 1'b0, 16'h0);
    send_op(sso_pkg::CmdSweep, 0, 0, '0, 1, 1'b1, 16'h0);
    send_op(sso_pkg::CmdSweep, 0, 0, '0, 31, 1'b0, 16'h0);
    send_op(sso_pkg::CmdMask, 0, 0, '0, 0, 1'b0, 16'hFFFF);
    send_op(sso_pkg::CmdMask, 0, 0, '0, 0, 1'b0, 16'h0000);
    send_op(sso_pkg::CmdRead, 2, 2, '0, 0, 1'b0, 16'h0);
    send_op(sso_pkg::CmdWrite, 2, 2, sso_pkg::QMin, 0, 1'b0, 16'h0);
    send_op(sso_pkg::CmdSweep, 0, 0, '0, 2, 1'b1, 16'h0);
    send_op(sso_pkg::CmdWrite, 0, 2, sso_pkg::QMax, 0, 1'b0, 16'h0);
    send_op(sso_pkg::CmdWrite, 0, 0, QOne >>> 20, 0, 1'b0, 16'h0);
    send_op(sso_pkg::CmdSweep, 0, 0, '0, 0, 1'b0, 16'h0);
    send_op(sso_pkg::CmdRead, 2, 0, '0, 0, 1'b0, 16'h0);
    send_op(sso_pkg::CmdRead, 1, 1, '0, 0, 1'b0, 16'h0);

    random_phase(5'd1, 100);
    random_phase(5'd3, 125);
    random_phase(5'd0, 75);
    random_phase(5'd4, 100);
    random_phase(5'd31, 25);
    random_phase(5'd6, 75);
    random_phase(5'd16, 25);
    random_phase(5'd2, 125);
    random_phase(5'd3, 50);

    drain();
    repeat (50) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("PASS symmetric_sweep_operator_engine_core");
    end else begin
      $display("FAIL symmetric_sweep_operator_engine_core");
    end
    $finish;
  end

endmodule
